// File: src/lss_pkg.sv
// lss_pkg: shared types and constants for the line-scan camera sequencer
// used by lss_step, lss_out_reg and linescan_camera_sequencer
package lss_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int INDEX_W    = 7;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 32;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	typedef struct packed {
		logic                cam_clock;
		logic                cam_si;
		logic                pixel_valid;
		logic [INDEX_W-1:0]  pixel_index;
		logic [SAMPLE_W-1:0] pixel_value;
		logic                line_done;
		logic                busy_res;
	} result_t;

endpackage

// File: src/linescan_camera_sequencer.sv
// linescan_camera_sequencer: top level of the line-scan camera sequencer
// depends on lss_pkg, lss_step and lss_out_reg
//
// slave side: one beat per event; s_tuser is the operation (0 = half-period
// tick, 1 = integration period expired, start a line), s_tdata the latest
// converter sample (low SAMPLE_BITS bits used)
// master side: exactly one result beat per input beat, in order; tdata holds
// the pin levels, pixel index and value and the busy flag, tuser marks a
// captured pixel, tlast marks the tick that ends the line
// path: an accepted beat passes the input register, then the result
// register, before it shows on the master side
// throughput: one beat per cycle while m_tready does not hold the output;
// the state update between the two registers is combinational
// reset: the block comes up active with the phase counter at minus two and
// both pins low, so the first ticks start a line at once
// stall: while m_tready is low the result register holds; if the input
// register is empty one more beat is taken into it, then s_tready drops
module linescan_camera_sequencer #(
	parameter int NUM_PIXELS  = 128,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [lss_pkg::S_TDATA_W-1:0]  s_tdata,  // sample
	input  logic                           s_tuser,  // operation
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [lss_pkg::M_TDATA_W-1:0]  m_tdata,  // cam_clock, cam_si, pixel_index, pixel_value, busy_res
	output logic                           m_tuser,  // pixel_valid
	output logic                           m_tlast   // line_done
);

	logic                          valid_s1;
	logic                          op_s1;
	logic [lss_pkg::SAMPLE_W-1:0]  sample_s1;
	logic                          adv;
	logic                          phase_idle;
	lss_pkg::result_t              res;

	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1     <= s_tuser;
			sample_s1 <= s_tdata;
		end
	end

	lss_step #(
		.NUM_PIXELS  (NUM_PIXELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (adv),
		.operation  (op_s1),
		.sample     (sample_s1),
		.res        (res),
		.phase_idle (phase_idle)
	);

	lss_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.res      (res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (!m_tdata[25] && !m_tdata[0] && !m_tuser))
		else $error("line end beat not idle with clock low");

	a_pixel_clk_low: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (!m_tdata[0] && !m_tdata[1] && m_tdata[25]))
		else $error("pixel captured with clock or si high");

	a_done_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.line_done) |=> phase_idle)
		else $error("phase counter not rewound after line end");

endmodule

// File: src/lss_step.sv
// lss_step: sequencer state (phase counter, clock, si, active) and the
// per-beat next-state and result logic; depends on lss_pkg
module lss_step #(
	parameter int NUM_PIXELS  = 128,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic                          operation,
	input  logic [lss_pkg::SAMPLE_W-1:0]  sample,
	output lss_pkg::result_t              res,
	output logic                          phase_idle
);

	localparam int PW = $clog2(2 * NUM_PIXELS + 1) + 1;
	localparam int XW = (PW > lss_pkg::INDEX_W) ? PW : lss_pkg::INDEX_W;
	localparam logic signed [PW-1:0] PH_START = -PW'(2);
	localparam logic signed [PW-1:0] PH_SI_HI = -PW'(1);
	localparam logic signed [PW-1:0] PH_FIRST = PW'(1);
	localparam logic signed [PW-1:0] PH_TWO   = PW'(2);
	localparam logic signed [PW-1:0] PH_END   = PW'(2 * NUM_PIXELS);

	logic signed [PW-1:0] phase_q, phase_d;
	logic                 clock_q, clock_d;
	logic                 si_q, si_d;
	logic                 active_q, active_d;
	logic [XW-1:0]        half;
	logic [lss_pkg::SAMPLE_W-1:0] smp;

	assign half = XW'(unsigned'(phase_q) >> 1);
	assign smp  = lss_pkg::SAMPLE_W'(sample[SAMPLE_BITS-1:0]);
	assign phase_idle = (phase_q == PH_START);

	always_comb begin
		phase_d  = phase_q;
		clock_d  = clock_q;
		si_d     = si_q;
		active_d = active_q;
		res.pixel_valid = 1'b0;
		res.pixel_index = '0;
		res.pixel_value = '0;
		res.line_done   = 1'b0;
		if (operation == lss_pkg::OP_START) begin
			active_d = 1'b1;
		end else if (active_q) begin
			clock_d = ~clock_q;
			if (phase_q >= PH_TWO && phase_q < PH_END) begin
				if (clock_q) begin
					res.pixel_valid = 1'b1;
					res.pixel_index = half[lss_pkg::INDEX_W-1:0];
					res.pixel_value = smp;
				end
				phase_d = phase_q + PW'(1);
			end else if (phase_q < PH_TWO) begin
				if (phase_q == PH_SI_HI) begin
					si_d = 1'b1;
				end else if (phase_q == PH_FIRST) begin
					si_d = 1'b0;
					res.pixel_valid = 1'b1;
					res.pixel_value = smp;
				end
				phase_d = phase_q + PW'(1);
			end else begin
				clock_d       = 1'b0;
				phase_d       = PH_START;
				active_d      = 1'b0;
				res.line_done = 1'b1;
			end
		end
		res.cam_clock = clock_d;
		res.cam_si    = si_d;
		res.busy_res  = active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			clock_q  <= 1'b0;
			si_q     <= 1'b0;
			active_q <= 1'b1;
		end else if (fire) begin
			phase_q  <= phase_d;
			clock_q  <= clock_d;
			si_q     <= si_d;
			active_q <= active_d;
		end
	end

endmodule

// File: src/lss_out_reg.sv
// lss_out_reg: result register on the master side, packs the result beat
// into tdata, tuser and tlast; depends on lss_pkg
module lss_out_reg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  lss_pkg::result_t               res,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [lss_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                           m_tuser,
	output logic                           m_tlast
);

	logic             valid_q;
	lss_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {6'd0, res_q.busy_res, res_q.pixel_value, res_q.pixel_index,
		res_q.cam_si, res_q.cam_clock};
	assign m_tuser  = res_q.pixel_valid;
	assign m_tlast  = res_q.line_done;

endmodule
